/* hw/rtl/bsc_pkg.sv */
package bsc_pkg;

   // Function codes of a request word
   localparam logic [2:0] FUNC_LOAD_ENTRY = 3'd0;
   localparam logic [2:0] FUNC_LOAD_AVAIL = 3'd1;
   localparam logic [2:0] FUNC_SET_REQUEST = 3'd2;
   localparam logic [2:0] FUNC_CHECK = 3'd3;
   localparam logic [2:0] FUNC_EVALUATE = 3'd4;

   // Status codes of a response word
   localparam logic [1:0] STATUS_LOADED = 2'd0;
   localparam logic [1:0] STATUS_SAFE = 2'd1;
   localparam logic [1:0] STATUS_UNSAFE = 2'd2;
   localparam logic [1:0] STATUS_DENIED = 2'd3;

   // Configuration register indexes
   localparam logic CSR_NUM_PROCESSES = 1'b0;
   localparam logic CSR_NUM_RESOURCES = 1'b1;

   typedef struct packed {
      logic [2:0]  func;
      logic [3:0]  proc_index;
      logic [2:0]  res_index;
      logic [15:0] alloc_value;
      logic [15:0] max_value;
      logic [15:0] amount;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [3:0] process;
      logic       last;
      logic       request_granted;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TEST_RD,
      ST_TEST_CMP,
      ST_ADD_RD,
      ST_ADD_UPD,
      ST_EMIT
   } state_type;

endpackage

/* hw/rtl/bsc_ram.sv */
module bsc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write one entry, register the read word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

/* hw/rtl/bankers_safety_checker_core.sv */
// Banker's algorithm safety engine.
// Request channel: a word on req_word is taken at a clock edge with start high
// and busy low. Load words (entry, available count, request element) answer
// one "loaded" response word in the next cycle and busy stays low, so loads go
// at one per cycle. A check or a granted request evaluation raises busy and
// walks the allocation and need memories: each process is tested per resource
// (memory read, then compare), each finishing process returns its allocation
// to work per resource (memory read, then update), a finished process is
// skipped, and passes repeat until all processes are done or a pass makes no
// progress. The engine then gives one response word per cycle for the safe
// sequence (P words, last marked) or a single unsafe word. A request that
// fails the availability test or names an unused process answers "denied" in
// the next cycle.
// Response channel: rsp_valid marks each word for exactly one cycle; the
// receiver cannot stall it.
// Configuration: csr_wr_en writes the process or resource count at once; write
// only while busy is low and no response is pending.
// Reset (synchronous): counts go to their maximum, work and done marks clear;
// the tables hold garbage until loaded.
module bankers_safety_checker_core #(
   parameter int MAX_PROCESSES = 16,
   parameter int MAX_RESOURCES = 8,
   parameter int UNIT_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  bsc_pkg::req_type req_word,
   output logic             rsp_valid,
   output bsc_pkg::rsp_type rsp_word,
   input  logic             csr_wr_en,
   input  logic             csr_index,
   input  logic [4:0]       csr_wr_data
);

   localparam int PW = $clog2(MAX_PROCESSES);
   localparam int RW = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
   localparam int PCW = $clog2(MAX_PROCESSES + 1);
   localparam int UB = UNIT_BITS;
   localparam int WB = UNIT_BITS + 4;
   localparam int DEPTH = 2 ** (PW + RW);

   bsc_pkg::state_type state_ff, state_in;
   logic [PW-1:0]  i_ff, i_in;
   logic [RW-1:0]  j_ff, j_in;
   logic [PW-1:0]  k_ff, k_in;
   logic [PCW-1:0] cnt_ff, cnt_in;
   logic           progress_ff, progress_in;
   logic           tent_ff, tent_in;
   logic [3:0]     tp_ff, tp_in;
   logic [MAX_PROCESSES-1:0] done_ff, done_in;
   logic [WB-1:0]  work_ff [MAX_RESOURCES];
   logic [WB-1:0]  work_in [MAX_RESOURCES];
   logic [UB-1:0]  avail_ff [MAX_RESOURCES];
   logic [UB-1:0]  avail_in [MAX_RESOURCES];
   logic [UB-1:0]  request_ff [MAX_RESOURCES];
   logic [UB-1:0]  request_in [MAX_RESOURCES];
   logic [3:0]     seq_ff [MAX_PROCESSES];
   logic [3:0]     seq_in [MAX_PROCESSES];
   logic [4:0]     num_proc_ff;
   logic [3:0]     num_res_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   bsc_pkg::rsp_type rsp_ff, rsp_in;

   logic [PCW-1:0] n_act;
   logic [RW:0]    m_act;
   logic                 mem_wr_en;
   logic [PW+RW-1:0]     mem_wr_addr;
   logic [PW+RW-1:0]     mem_rd_addr;
   logic [UB-1:0]        alloc_wr, alloc_rd;
   logic [UB:0]          need_wr, need_rd;
   logic [UB-1:0]        av_u, mv_u, amt_u;
   logic                 adj;
   logic [UB-1:0]        adj_req;
   logic signed [UB+4:0] nd_ext, wk_ext;
   logic [WB:0]          sum;
   logic [WB-1:0]        sum_sat;
   logic                 denied;

   // Saturate the configured counts into their legal ranges
   always_comb begin
      if (num_proc_ff == 5'd0) begin
         n_act = PCW'(1);
      end else if (int'(num_proc_ff) > MAX_PROCESSES) begin
         n_act = PCW'(MAX_PROCESSES);
      end else begin
         n_act = PCW'(num_proc_ff);
      end
      if (num_res_ff == 4'd0) begin
         m_act = (RW+1)'(1);
      end else if (int'(num_res_ff) > MAX_RESOURCES) begin
         m_act = (RW+1)'(MAX_RESOURCES);
      end else begin
         m_act = (RW+1)'(num_res_ff);
      end
   end

   // Payload at table width
   assign av_u = UB'(req_word.alloc_value);
   assign mv_u = UB'(req_word.max_value);
   assign amt_u = UB'(req_word.amount);
   assign alloc_wr = av_u;
   assign need_wr = {1'b0, mv_u} - {1'b0, av_u};
   assign mem_wr_addr = {PW'(req_word.proc_index), RW'(req_word.res_index)};
   assign mem_rd_addr = {i_ff, j_ff};

   bsc_ram #(.WIDTH(UB), .DEPTH(DEPTH)) u_alloc_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (alloc_wr),
      .rd_addr (mem_rd_addr),
      .rd_data (alloc_rd)
   );

   bsc_ram #(.WIDTH(UB + 1), .DEPTH(DEPTH)) u_need_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (need_wr),
      .rd_addr (mem_rd_addr),
      .rd_data (need_rd)
   );

   // Fit test and work update for the current element
   assign adj = tent_ff && (int'(i_ff) == int'(tp_ff));
   assign adj_req = adj ? request_ff[j_ff] : '0;
   assign nd_ext = $signed({{4{need_rd[UB]}}, need_rd}) - $signed({5'b0, adj_req});
   assign wk_ext = $signed({1'b0, work_ff[j_ff]});
   assign sum = {1'b0, work_ff[j_ff]} + (WB+1)'(alloc_rd) + (WB+1)'(adj_req);
   assign sum_sat = sum[WB] ? '1 : sum[WB-1:0];

   // Availability test of the request vector
   always_comb begin
      denied = 1'b0;
      for (int r = 0; r < MAX_RESOURCES; r++) begin
         if (r < int'(m_act) && request_ff[r] > avail_ff[r]) begin
            denied = 1'b1;
         end
      end
   end

   // Next state, table writes and response word
   always_comb begin
      logic next_proc;
      logic [PCW-1:0] cnt_v;
      logic prog_v;
      state_in = state_ff;
      i_in = i_ff;
      j_in = j_ff;
      k_in = k_ff;
      cnt_in = cnt_ff;
      progress_in = progress_ff;
      tent_in = tent_ff;
      tp_in = tp_ff;
      done_in = done_ff;
      work_in = work_ff;
      avail_in = avail_ff;
      request_in = request_ff;
      seq_in = seq_ff;
      rsp_valid_in = 1'b0;
      rsp_in = '0;
      mem_wr_en = 1'b0;
      next_proc = 1'b0;
      cnt_v = cnt_ff;
      prog_v = progress_ff;
      case (state_ff)
         bsc_pkg::ST_IDLE: begin
            if (start) begin
               case (req_word.func)
                  bsc_pkg::FUNC_LOAD_ENTRY: begin
                     mem_wr_en = (int'(req_word.proc_index) < MAX_PROCESSES) &&
                                 (int'(req_word.res_index) < MAX_RESOURCES);
                     rsp_valid_in = 1'b1;
                     rsp_in.status = bsc_pkg::STATUS_LOADED;
                     rsp_in.last = 1'b1;
                  end
                  bsc_pkg::FUNC_LOAD_AVAIL: begin
                     if (int'(req_word.res_index) < MAX_RESOURCES) begin
                        avail_in[RW'(req_word.res_index)] = amt_u;
                     end
                     rsp_valid_in = 1'b1;
                     rsp_in.status = bsc_pkg::STATUS_LOADED;
                     rsp_in.last = 1'b1;
                  end
                  bsc_pkg::FUNC_SET_REQUEST: begin
                     if (int'(req_word.res_index) < MAX_RESOURCES) begin
                        request_in[RW'(req_word.res_index)] = amt_u;
                     end
                     rsp_valid_in = 1'b1;
                     rsp_in.status = bsc_pkg::STATUS_LOADED;
                     rsp_in.last = 1'b1;
                  end
                  bsc_pkg::FUNC_CHECK, bsc_pkg::FUNC_EVALUATE: begin
                     if (req_word.func == bsc_pkg::FUNC_EVALUATE &&
                         (int'(req_word.proc_index) >= int'(n_act) || denied)) begin
                        rsp_valid_in = 1'b1;
                        rsp_in.status = bsc_pkg::STATUS_DENIED;
                        rsp_in.last = 1'b1;
                     end else begin
                        tent_in = (req_word.func == bsc_pkg::FUNC_EVALUATE);
                        tp_in = req_word.proc_index;
                        for (int r = 0; r < MAX_RESOURCES; r++) begin
                           work_in[r] = tent_in ? WB'(avail_ff[r] - request_ff[r])
                                                : WB'(avail_ff[r]);
                        end
                        done_in = '0;
                        cnt_in = '0;
                        progress_in = 1'b0;
                        i_in = '0;
                        j_in = '0;
                        state_in = bsc_pkg::ST_TEST_RD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         bsc_pkg::ST_TEST_RD: begin
            if (done_ff[i_ff]) begin
               next_proc = 1'b1;
            end else begin
               state_in = bsc_pkg::ST_TEST_CMP;
            end
         end
         bsc_pkg::ST_TEST_CMP: begin
            if (nd_ext > wk_ext) begin
               next_proc = 1'b1;
            end else if (int'(j_ff) + 1 == int'(m_act)) begin
               j_in = '0;
               state_in = bsc_pkg::ST_ADD_RD;
            end else begin
               j_in = j_ff + 1'b1;
               state_in = bsc_pkg::ST_TEST_RD;
            end
         end
         bsc_pkg::ST_ADD_RD: begin
            state_in = bsc_pkg::ST_ADD_UPD;
         end
         bsc_pkg::ST_ADD_UPD: begin
            work_in[j_ff] = sum_sat;
            if (int'(j_ff) + 1 == int'(m_act)) begin
               done_in[i_ff] = 1'b1;
               seq_in[cnt_ff[PW-1:0]] = 4'(i_ff);
               cnt_v = cnt_ff + 1'b1;
               prog_v = 1'b1;
               cnt_in = cnt_v;
               progress_in = 1'b1;
               next_proc = 1'b1;
            end else begin
               j_in = j_ff + 1'b1;
               state_in = bsc_pkg::ST_ADD_RD;
            end
         end
         bsc_pkg::ST_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_in.status = bsc_pkg::STATUS_SAFE;
            rsp_in.process = seq_ff[k_ff];
            rsp_in.request_granted = tent_ff;
            k_in = k_ff + 1'b1;
            if (int'(k_ff) + 1 == int'(cnt_ff)) begin
               rsp_in.last = 1'b1;
               state_in = bsc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bsc_pkg::ST_IDLE;
         end
      endcase
      // Advance to the next process, close the pass at the end
      if (next_proc) begin
         j_in = '0;
         if (int'(i_ff) + 1 == int'(n_act)) begin
            if (cnt_v == n_act) begin
               k_in = '0;
               state_in = bsc_pkg::ST_EMIT;
            end else if (!prog_v) begin
               rsp_valid_in = 1'b1;
               rsp_in.status = bsc_pkg::STATUS_UNSAFE;
               rsp_in.last = 1'b1;
               rsp_in.request_granted = tent_ff;
               state_in = bsc_pkg::ST_IDLE;
            end else begin
               i_in = '0;
               progress_in = 1'b0;
               state_in = bsc_pkg::ST_TEST_RD;
            end
         end else begin
            i_in = i_ff + 1'b1;
            state_in = bsc_pkg::ST_TEST_RD;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bsc_pkg::ST_IDLE;
         i_ff <= '0;
         j_ff <= '0;
         k_ff <= '0;
         cnt_ff <= '0;
         progress_ff <= 1'b0;
         tent_ff <= 1'b0;
         done_ff <= '0;
         rsp_valid_ff <= 1'b0;
         num_proc_ff <= 5'd16;
         num_res_ff <= 4'd8;
         for (int r = 0; r < MAX_RESOURCES; r++) begin
            work_ff[r] <= '0;
         end
      end else begin
         state_ff <= state_in;
         i_ff <= i_in;
         j_ff <= j_in;
         k_ff <= k_in;
         cnt_ff <= cnt_in;
         progress_ff <= progress_in;
         tent_ff <= tent_in;
         done_ff <= done_in;
         rsp_valid_ff <= rsp_valid_in;
         work_ff <= work_in;
         if (csr_wr_en && csr_index == bsc_pkg::CSR_NUM_PROCESSES) begin
            num_proc_ff <= csr_wr_data;
         end
         if (csr_wr_en && csr_index == bsc_pkg::CSR_NUM_RESOURCES) begin
            num_res_ff <= csr_wr_data[3:0];
         end
      end
   end

   // Payload state
   always_ff @(posedge clock) begin
      tp_ff <= tp_in;
      avail_ff <= avail_in;
      request_ff <= request_in;
      seq_ff <= seq_in;
      rsp_ff <= rsp_in;
   end

   assign busy = (state_ff != bsc_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word = rsp_ff;

   a_load_answers: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_word.func == bsc_pkg::FUNC_LOAD_ENTRY)
      |=> (rsp_valid && rsp_word.last))
      else $error("load word gave no response");

   a_compare_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bsc_pkg::ST_TEST_CMP) |-> ($past(state_ff) == bsc_pkg::ST_TEST_RD))
      else $error("need compared without a memory read");

   a_done_count: assert property (@(posedge clock) disable iff (reset)
      $countones(done_ff) == int'(cnt_ff))
      else $error("done marks disagree with sequence count");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      busy |-> (cnt_ff <= n_act))
      else $error("sequence count beyond active processes");

endmodule
